// ----- hdl/sa_lru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_lru_pkg
// Shared constants for the set-associative LRU tag array.
// ----------------------------------------------------------------------------
package sa_lru_pkg;

  localparam int DEF_SETS      = 64;
  localparam int DEF_WAYS      = 4;
  localparam int DEF_ADDR_BITS = 48;

  localparam int STAMP_W     = 32;
  localparam int SHIFT_W     = 4;
  localparam int WAY_OUT_W   = 4;
  localparam int OUT_TDATA_W = 8;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd6;

  // request kinds carried on tuser
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_INVAL  = 1'b1;

endpackage

// ----- hdl/sa_lru_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_lru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sa_lru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/set_assoc_lru_tag_array.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_array
// Set-associative tag array with LRU replacement by recency stamp.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake          | Payload
// cfg      | in  | cfg_wr_en          | cfg_wr_data = address to line shift
// s (req)  | in  | s_tvalid/s_tready  | tuser = req_type, tdata = address, stamp
// m (resp) | out | m_tvalid/m_tready  | tdata = hit, way_touched
//
// Steps: an access on a hit is accept, set read, compare when SETS is a power
// of two; a miss adds the one-way-a-cycle victim scan and a fill step. For
// other SETS the set index is first worked out by a residue fold of 8-bit
// chunks, then a reciprocal multiply. Invalidate sweeps the tag RAM. Reset: a
// clearing pass over every set runs with s_tready low. A stalled result holds
// the finishing step; the next item is taken while the result register
// still waits.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_array #(
  parameter int SETS      = sa_lru_pkg::DEF_SETS,
  parameter int WAYS      = sa_lru_pkg::DEF_WAYS,
  parameter int ADDR_BITS = sa_lru_pkg::DEF_ADDR_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [sa_lru_pkg::SHIFT_W-1:0]       cfg_wr_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // address, access stamp
  input  logic [((ADDR_BITS+sa_lru_pkg::STAMP_W+7)/8)*8-1:0] s_tdata,
  // req_type
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // hit, way_touched, zero fill
  output logic [sa_lru_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int STAMP_W   = sa_lru_pkg::STAMP_W;
  localparam int SET_W     = SETS > 1 ? $clog2(SETS) : 1;
  localparam int WAY_W     = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int ENT_W     = 1 + ADDR_BITS + STAMP_W;
  localparam int ROW_W     = WAYS * ENT_W;
  localparam bit SETS_POW2 = (SETS & (SETS - 1)) == 0;
  localparam int FILL_W    = sa_lru_pkg::OUT_TDATA_W - 1 - sa_lru_pkg::WAY_OUT_W;

  // set index for other SETS: fold 8-bit chunks by their weight 2^(8i) mod SETS,
  // then take the remainder of the folded sum by reciprocal multiplication
  localparam int CHUNK_W  = 8;
  localparam int CHUNKS   = (ADDR_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int FOLD_W   = CHUNK_W + SET_W + 3;
  localparam int RECIP_SH = FOLD_W + SET_W;
  localparam int RECIP_W  = FOLD_W + 2;
  localparam int PROD_W   = FOLD_W + RECIP_W;

  function automatic logic [CHUNKS*SET_W-1:0] chunk_weights();
    logic [CHUNKS*SET_W-1:0] wt;
    longint unsigned         k;
    wt = '0;
    k  = 64'd1 % 64'(SETS);
    for (int i = 0; i < CHUNKS; i++) begin
      wt[i*SET_W +: SET_W] = SET_W'(k);
      k = (k << CHUNK_W) % 64'(SETS);
    end
    return wt;
  endfunction

  localparam logic [CHUNKS*SET_W-1:0] WEIGHTS = chunk_weights();
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(SETS) - 64'd1) / 64'(SETS));
  localparam logic [FOLD_W-1:0]  SETS_F = FOLD_W'(SETS);

  localparam logic [SET_W-1:0] LAST_SET   = SET_W'(SETS - 1);
  localparam logic [WAY_W-1:0] LAST_WAY   = WAY_W'(WAYS - 1);
  localparam logic [1:0]       LAST_PHASE = 2'd2;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SET   = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;

  logic [2:0]                       state;
  logic [sa_lru_pkg::SHIFT_W-1:0]   size_shift;
  logic [ADDR_BITS-1:0]             line_q;
  logic [STAMP_W-1:0]               stamp_q;
  logic [1:0]                       set_phase;
  logic [FOLD_W-1:0]                fold_q;
  logic [FOLD_W-1:0]                quo_q;
  logic [SET_W-1:0]                 set_q;
  logic                             emit_inv;
  logic [WAY_W-1:0]                 scan_way;
  logic [STAMP_W:0]                 oldest;
  logic [WAY_W-1:0]                 victim;
  logic                             out_valid;
  logic                             out_hit;
  logic [sa_lru_pkg::WAY_OUT_W-1:0] out_way;

  logic [ADDR_BITS-1:0]       line_in;
  logic [CHUNKS*CHUNK_W-1:0]  line_pad;
  logic [FOLD_W-1:0]          fold_sum;
  logic [PROD_W-1:0]          recip_prod;
  logic [FOLD_W-1:0]          quo_next;
  logic [FOLD_W-1:0]          set_rem;
  logic [SET_W-1:0]           set_mod;
  logic [SET_W-1:0]           set_pow2;
  logic                       hit_any;
  logic [WAY_W-1:0]           hit_way;
  logic [ENT_W-1:0]           scan_ent;
  logic [STAMP_W:0]           scan_age;
  logic [WAY_W-1:0]           touch_way;
  logic [ROW_W-1:0]           row_upd;
  logic                       out_free;

  logic                 ram_we;
  logic [ROW_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [SET_W-1:0]     ram_raddr;
  logic [ROW_W-1:0]     ram_rdata;

  assign line_in  = s_tdata[ADDR_BITS-1:0] >> size_shift;
  assign set_pow2 = line_q[SET_W-1:0] & LAST_SET;
  assign out_free = !out_valid || m_tready;

  assign line_pad = (CHUNKS*CHUNK_W)'(line_q);

  always_comb begin
    fold_sum = '0;
    for (int i = 0; i < CHUNKS; i++) begin
      fold_sum = fold_sum + FOLD_W'(line_pad[i*CHUNK_W +: CHUNK_W]) *
                            FOLD_W'(WEIGHTS[i*SET_W +: SET_W]);
    end
  end

  // quotient is exact for every folded sum below 2^FOLD_W
  assign recip_prod = {{RECIP_W{1'b0}}, fold_q} * {{FOLD_W{1'b0}}, RECIP};
  assign quo_next   = FOLD_W'(recip_prod >> RECIP_SH);
  assign set_rem    = fold_q - quo_q * SETS_F;
  assign set_mod    = set_rem[SET_W-1:0];

  // parallel tag compare, lowest way wins
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && ram_rdata[w*ENT_W + ENT_W - 1] &&
          ram_rdata[w*ENT_W + STAMP_W +: ADDR_BITS] == line_q) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign scan_ent = ram_rdata[scan_way*ENT_W +: ENT_W];
  assign scan_age = scan_ent[ENT_W-1] ? {1'b0, scan_ent[STAMP_W-1:0]} : '0;

  // hit and fill both leave the way valid with the line and the new stamp
  assign touch_way = (state == ST_LOOK) ? hit_way : victim;
  always_comb begin
    row_upd = ram_rdata;
    row_upd[touch_way*ENT_W +: ENT_W] = {1'b1, line_q, stamp_q};
  end

  assign ram_re    = (state == ST_SET) && (SETS_POW2 || set_phase == LAST_PHASE);
  assign ram_raddr = SETS_POW2 ? set_pow2 : set_mod;
  assign ram_we    = (state == ST_CLEAR) ||
                     (((state == ST_LOOK && hit_any) || state == ST_FILL) && out_free);
  assign ram_wdata = (state == ST_CLEAR) ? '0 : row_upd;

  sa_lru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_q),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      set_q      <= '0;
      emit_inv   <= 1'b0;
      out_valid  <= 1'b0;
      size_shift <= sa_lru_pkg::SHIFT_RST;
    end else begin
      if (cfg_wr_en) begin
        size_shift <= cfg_wr_data;
      end
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (set_q == LAST_SET) begin
            if (!emit_inv || out_free) begin
              if (emit_inv) begin
                out_valid <= 1'b1;
                out_hit   <= 1'b0;
                out_way   <= '0;
              end
              emit_inv <= 1'b0;
              set_q    <= '0;
              state    <= ST_IDLE;
            end
          end else begin
            set_q <= set_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == sa_lru_pkg::REQ_INVAL) begin
              emit_inv <= 1'b1;
              set_q    <= '0;
              state    <= ST_CLEAR;
            end else begin
              line_q    <= line_in;
              stamp_q   <= s_tdata[ADDR_BITS +: STAMP_W];
              set_phase <= '0;
              state     <= ST_SET;
            end
          end
        end
        ST_SET: begin
          if (ram_re) begin
            set_q <= ram_raddr;
            state <= ST_LOOK;
          end else begin
            // fold_q settles first, then quo_q is taken from the settled fold
            fold_q    <= fold_sum;
            quo_q     <= quo_next;
            set_phase <= set_phase + 1'b1;
          end
        end
        ST_LOOK: begin
          if (hit_any) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_hit   <= 1'b1;
              out_way   <= sa_lru_pkg::WAY_OUT_W'(hit_way);
              state     <= ST_IDLE;
            end
          end else begin
            scan_way <= '0;
            oldest   <= {1'b1, {STAMP_W{1'b0}}};
            victim   <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_age < oldest) begin
            oldest <= scan_age;
            victim <= scan_way;
          end
          if (scan_way == LAST_WAY) begin
            state <= ST_FILL;
          end else begin
            scan_way <= scan_way + 1'b1;
          end
        end
        ST_FILL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_hit   <= 1'b0;
            out_way   <= sa_lru_pkg::WAY_OUT_W'(victim);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{FILL_W{1'b0}}, out_way, out_hit};

endmodule

// ----- hdl/sa_lru_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_lru_chk
// Port-level checks for the LRU tag array, bound to the top level.
// ----------------------------------------------------------------------------
module sa_lru_chk #(
  parameter int WAYS = sa_lru_pkg::DEF_WAYS
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [sa_lru_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // the reported way exists
  a_way_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:1] < WAYS)
    else $error("way out of range");

  // clearing pass after reset keeps the input closed
  a_clear_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready && !m_tvalid)
    else $error("ready or result right after reset");

  // one item in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

endmodule

bind set_assoc_lru_tag_array sa_lru_chk #(
  .WAYS (WAYS)
) u_sa_lru_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- bench/set_assoc_lru_tag_array_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_array_test
// Self-checking bench for the set-associative LRU tag array. Access and
// invalidate items stream in with random gaps, results stream out under
// random backpressure, and every result is checked in order against a
// behavioral tag/valid/stamp array kept in the bench. Line size is swept
// across its full range, extremes included.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_array_test;

  localparam int SETS        = sa_lru_pkg::DEF_SETS;
  localparam int WAYS        = sa_lru_pkg::DEF_WAYS;
  localparam int ADDR_BITS   = sa_lru_pkg::DEF_ADDR_BITS;
  localparam int STAMP_W     = sa_lru_pkg::STAMP_W;
  localparam int SHIFT_W     = sa_lru_pkg::SHIFT_W;
  localparam int WAY_OUT_W   = sa_lru_pkg::WAY_OUT_W;
  localparam int OUT_TDATA_W = sa_lru_pkg::OUT_TDATA_W;
  localparam int ENTRIES     = SETS * WAYS;
  localparam int S_W         = ((ADDR_BITS + STAMP_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 2 * SETS + 16;
  localparam int PHASE_ITEMS = 150;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [STAMP_W-1:0]   stamp_t;

  typedef struct {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 kind;
    addr_t                addr;
  } lookup_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [SHIFT_W-1:0]     cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_W-1:0]         s_tdata = '0;
  logic                   s_tuser = sa_lru_pkg::REQ_ACCESS;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // shadow copy of the tag array
  logic                   tag_valid [ENTRIES];
  addr_t                  tag_line  [ENTRIES];
  stamp_t                 tag_stamp [ENTRIES];
  logic [SHIFT_W-1:0]     shift_q = sa_lru_pkg::SHIFT_RST;

  lookup_t                lookup_expect [$];
  int                     err_count = 0;
  int                     cycle_count = 0;
  bit                     src_idle_on = 1'b0;
  bit                     sink_idle_on = 1'b0;
  bit                     src_busy = 1'b0;
  int                     sink_stall = 0;

  // line pool for well-formed traffic
  addr_t                  pool_line [8];
  stamp_t                 stamp_ctr;

  set_assoc_lru_tag_array dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic tag_lookup(input logic kind, input addr_t addr, input stamp_t stamp,
                            output logic hit, output logic [WAY_OUT_W-1:0] way);
    addr_t       line;
    int          base;
    int          victim;
    logic [32:0] oldest;
    logic [32:0] age;
    hit = 1'b0;
    way = '0;
    if (kind == sa_lru_pkg::REQ_INVAL) begin
      for (int i = 0; i < ENTRIES; i++) tag_valid[i] = 1'b0;
      return;
    end
    line = addr >> shift_q;
    base = int'(line % SETS) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (tag_valid[base + w] && tag_line[base + w] == line) begin
        tag_stamp[base + w] = stamp;
        hit = 1'b1;
        way = WAY_OUT_W'(w);
        return;
      end
    end
    // empty way ages as zero; ties go to the lowest way
    victim = 0;
    oldest = '1;
    for (int w = 0; w < WAYS; w++) begin
      age = tag_valid[base + w] ? {1'b0, tag_stamp[base + w]} : 33'd0;
      if (age < oldest) begin
        oldest = age;
        victim = w;
      end
    end
    tag_valid[base + victim] = 1'b1;
    tag_line[base + victim]  = line;
    tag_stamp[base + victim] = stamp;
    way = WAY_OUT_W'(victim);
  endtask

  task automatic send_req(input logic kind, input addr_t addr, input stamp_t stamp);
    lookup_t exp;
    int      gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      if (src_busy) begin
        s_tvalid <= 1'b0;
        src_busy = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= S_W'({stamp, addr});
    src_busy = 1'b1;
    do @(posedge clk); while (!s_tready);
    exp.kind = kind;
    exp.addr = addr;
    tag_lookup(kind, addr, stamp, exp.hit, exp.way);
    lookup_expect.push_back(exp);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    if (src_busy) begin
      s_tvalid <= 1'b0;
      src_busy = 1'b0;
    end
    while (lookup_expect.size() != 0) @(posedge clk);
  endtask

  task automatic set_shift_cfg(input logic [SHIFT_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shift_q = v;
  endtask

  always @(posedge clk) begin
    if (sink_idle_on && sink_stall == 0 && $urandom_range(0, 7) == 0)
      sink_stall = $urandom_range(1, 17);
    if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lookup_t exp;
    if (!rst && m_tvalid && m_tready) begin
      if (lookup_expect.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: tdata=%h", m_tdata);
      end else begin
        exp = lookup_expect.pop_front();
        if (m_tdata[0] !== exp.hit || m_tdata[WAY_OUT_W:1] !== exp.way) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch kind=%0d addr=%h: expected hit=%0d way=%0d, got hit=%b way=%b",
                     exp.kind, exp.addr, exp.hit, exp.way, m_tdata[0], m_tdata[WAY_OUT_W:1]);
        end
      end
    end
  end

  task automatic test_directed();
    // reset line size (64 B); lines in set 0 but for the two all-ones ones, in set 63
    send_req(sa_lru_pkg::REQ_INVAL, '0, '0);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h0000, 32'd0);
    // valid way with stamp 0 ties with empty ways, so way 0 is taken again
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h1000, 32'd5);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h2000, 32'd7);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h3000, 32'd9);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h4000, 32'hFFFF_FFFF);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h2010, 32'd11);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h5000, 32'd12);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h1000, 32'd13);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'hFFFF_FFFF_FFC0, 32'd0);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h8000_0000_0000, 32'd1);
    // invalidate ignores its address and stamp
    send_req(sa_lru_pkg::REQ_INVAL, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h2000, 32'd3);
    send_req(sa_lru_pkg::REQ_ACCESS, 48'h2000, 32'd4);
  endtask

  task automatic test_shift_sweep();
    logic [SHIFT_W-1:0] shifts [4];
    addr_t              base_addr;
    shifts = '{4'd0, 4'd12, 4'd15, 4'd13};
    base_addr = 48'hA5A5_1234_5678;
    foreach (shifts[i]) begin
      set_shift_cfg(shifts[i]);
      send_req(sa_lru_pkg::REQ_ACCESS, base_addr, 32'd100 + i);
      send_req(sa_lru_pkg::REQ_ACCESS, base_addr ^ 48'h1, 32'd200 + i);
      send_req(sa_lru_pkg::REQ_ACCESS, base_addr + (48'h1 << shifts[i]), 32'd300 + i);
    end
  endtask

  function automatic addr_t rand_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  task automatic fill_pool();
    addr_t line;
    int    set_a;
    int    set_b;
    set_a = $urandom_range(0, SETS - 1);
    set_b = $urandom_range(0, SETS - 1);
    foreach (pool_line[i]) begin
      line = rand_addr() >> shift_q;
      line = (line & ~addr_t'(SETS - 1)) | addr_t'((i < 6) ? set_a : set_b);
      pool_line[i] = line;
    end
  endtask

  task automatic random_item();
    addr_t  addr;
    addr_t  low_mask;
    stamp_t stamp;
    int     pick;
    logic   kind;
    pick = $urandom_range(0, 99);
    kind = (pick < 2) ? sa_lru_pkg::REQ_INVAL : sa_lru_pkg::REQ_ACCESS;
    low_mask = (addr_t'(1) << shift_q) - 1;
    if (pick < 80)
      addr = (pool_line[$urandom_range(0, 7)] << shift_q) | (rand_addr() & low_mask);
    else
      addr = rand_addr();
    pick = $urandom_range(0, 19);
    if (pick == 0)
      stamp = '0;
    else if (pick == 1)
      stamp = '1;
    else if (pick < 4)
      stamp = $urandom;
    else begin
      stamp_ctr += $urandom_range(1, 3);
      stamp = stamp_ctr;
    end
    send_req(kind, addr, stamp);
  endtask

  task automatic test_random();
    logic [SHIFT_W-1:0] shifts [6];
    shifts = '{4'd6, 4'd0, 4'd12, 4'd15, 4'($urandom_range(0, 15)), 4'd3};
    stamp_ctr = $urandom;
    foreach (shifts[p]) begin
      src_idle_on  = (p != 5);
      sink_idle_on = (p != 5) && (p != 1);
      set_shift_cfg(shifts[p]);
      fill_pool();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off until the pipe has fully drained
        if (p == 2 && n == PHASE_ITEMS / 2) settle();
        if (n % 50 == 49) fill_pool();
        random_item();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_shift_sweep();
    test_random();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lookup_expect.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sa_lru_pkg.sv
hdl/sa_lru_ram.sv
hdl/set_assoc_lru_tag_array.sv
hdl/sa_lru_chk.sv
bench/set_assoc_lru_tag_array_test.sv
